FILE: hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Beat types and result codes shared by the decoder and its environment.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] code_unit;
    kind_t       result_kind;
    logic        run_last;
  } out_beat_t;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'h003F;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
  localparam logic [20:0] SUPP_PLANE_BASE  = 21'h010000;
  localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST       = 21'h00D800;
  localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
  localparam int          MAX_RESULTS      = 3;

endpackage

FILE: hw/rtl/utf8_to_utf16_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Takes one UTF-8 byte per input beat and delivers UTF-16 code units,
// decode errors and end-of-string markers, one result per output beat.
//
// The input channel (in_valid, in_ready, in_beat) carries a byte and a flag
// that marks the last byte of a string. The output channel (out_valid,
// out_ready, out_beat) carries the results of each byte in order, and the
// last result of a byte has run_last set. A byte may give no result, or up
// to three.
// The byte is decoded in the cycle it is accepted, and its first result is
// presented in the next cycle. A byte with one result or none can be taken
// every cycle while out_ready is high; a byte with more results holds off
// the next byte while its results drain from the buffer, one beat a cycle.
// When the receiver stalls, results wait in the buffer. in_ready stays low
// while more than one result is waiting, or while one waits and out_ready
// is low.
// Reset empties the buffer, closes any open sequence and clears loose_mode.
// loose_mode_we writes loose_mode_data, which turns each error into '?'.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 loose_mode_we,
  input  logic                 loose_mode_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u8u16_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8u16_pkg::out_beat_t out_beat
);
  import u8u16_pkg::*;

  logic        loose_mode;
  logic [1:0]  bytes_pending;
  logic [2:0]  sequence_length;
  logic [20:0] code_point_acc;
  logic        all_trails_seen;

  logic [1:0]  bytes_pending_next;
  logic [2:0]  sequence_length_next;
  logic [20:0] code_point_acc_next;
  logic        all_trails_seen_next;

  out_beat_t   res_buf [MAX_RESULTS];
  logic [1:0]  count;

  out_beat_t   res [MAX_RESULTS];
  logic [1:0]  res_n;
  logic        in_fire;
  logic        out_fire;

  function automatic out_beat_t make_unit(input logic [15:0] unit, input kind_t kind);
    out_beat_t r;
    r.code_unit   = unit;
    r.result_kind = kind;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic out_beat_t make_error(input logic loose);
    out_beat_t r;
    if (loose) begin
      r = make_unit(REPLACEMENT_UNIT, KIND_UNIT);
    end else begin
      r = make_unit(16'h0000, KIND_ERROR);
    end
    return r;
  endfunction

  assign in_ready  = (count == 2'd0) || ((count == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign out_beat  = res_buf[0];

  always_comb begin
    logic [7:0]  b;
    logic        is_lead;
    logic        used;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] c;
    b       = in_beat.data_byte;
    is_lead = (b < 8'h80) || ((b >= 8'hC2) && (b <= 8'hF4));
    used    = 1'b0;
    bad     = 1'b0;
    cp      = '0;
    c       = '0;
    res_n   = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = make_unit(16'h0000, KIND_UNIT);
    end
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    code_point_acc_next  = code_point_acc;
    all_trails_seen_next = all_trails_seen;

    if (bytes_pending != 2'd0) begin
      if (is_lead) begin
        res[res_n] = make_error(loose_mode);
        res_n = res_n + 2'd1;
        bytes_pending_next   = 2'd0;
        sequence_length_next = 3'd0;
        code_point_acc_next  = '0;
        all_trails_seen_next = 1'b1;
      end else begin
        used = 1'b1;
        cp = {code_point_acc[14:0], b[5:0]};
        code_point_acc_next = cp;
        if (b > 8'hBF) begin
          all_trails_seen_next = 1'b0;
        end
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending_next == 2'd0) begin
          bad = !all_trails_seen_next;
          if (sequence_length == 3'd2) begin
            bad = bad || (cp < 21'h80);
          end else if (sequence_length == 3'd3) begin
            bad = bad || (cp < 21'h800) || ((cp >= SURR_FIRST) && (cp <= SURR_LAST));
          end else begin
            bad = bad || (cp < SUPP_PLANE_BASE) || (cp > MAX_CODE_POINT);
          end
          if (bad) begin
            res[res_n] = make_error(loose_mode);
            res_n = res_n + 2'd1;
          end else if (cp >= SUPP_PLANE_BASE) begin
            c = cp - SUPP_PLANE_BASE;
            res[res_n] = make_unit(HIGH_SURR_BASE | {6'd0, c[19:10]}, KIND_UNIT);
            res_n = res_n + 2'd1;
            res[res_n] = make_unit(LOW_SURR_BASE | {6'd0, c[9:0]}, KIND_UNIT);
            res_n = res_n + 2'd1;
          end else begin
            res[res_n] = make_unit(cp[15:0], KIND_UNIT);
            res_n = res_n + 2'd1;
          end
          sequence_length_next = 3'd0;
          code_point_acc_next  = '0;
          all_trails_seen_next = 1'b1;
        end
      end
    end

    if (!used) begin
      if (b < 8'h80) begin
        res[res_n] = make_unit({8'h00, b}, KIND_UNIT);
        res_n = res_n + 2'd1;
      end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
        sequence_length_next = 3'd2;
        bytes_pending_next   = 2'd1;
        code_point_acc_next  = {16'd0, b[4:0]};
      end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
        sequence_length_next = 3'd3;
        bytes_pending_next   = 2'd2;
        code_point_acc_next  = {17'd0, b[3:0]};
      end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
        sequence_length_next = 3'd4;
        bytes_pending_next   = 2'd3;
        code_point_acc_next  = {18'd0, b[2:0]};
      end else begin
        res[res_n] = make_error(loose_mode);
        res_n = res_n + 2'd1;
      end
    end

    if (in_beat.final_byte) begin
      if (bytes_pending_next != 2'd0) begin
        res[res_n] = make_error(loose_mode);
        res_n = res_n + 2'd1;
        bytes_pending_next   = 2'd0;
        sequence_length_next = 3'd0;
        code_point_acc_next  = '0;
        all_trails_seen_next = 1'b1;
      end
      res[res_n] = make_unit(16'h0000, KIND_END);
      res_n = res_n + 2'd1;
    end

    if (res_n != 2'd0) begin
      res[res_n - 2'd1].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loose_mode <= 1'b0;
    end else if (loose_mode_we) begin
      loose_mode <= loose_mode_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 2'd0;
      sequence_length <= 3'd0;
      code_point_acc  <= '0;
      all_trails_seen <= 1'b1;
    end else if (in_fire) begin
      bytes_pending   <= bytes_pending_next;
      sequence_length <= sequence_length_next;
      code_point_acc  <= code_point_acc_next;
      all_trails_seen <= all_trails_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (in_fire) begin
      count <= res_n;
    end else if (out_fire) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_buf[i] <= res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_buf[i] <= res_buf[i + 1];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_beat.final_byte) |=> (bytes_pending == 2'd0))
    else $error("Sequence still open after the final byte of a string.");

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_beat.final_byte) |=> out_valid)
    else $error("Final byte produced no end-of-string result.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.run_last) |-> (count == 2'd1))
    else $error("Run marked last while further results are buffered.");

  assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != 2'd0) |-> ({1'b0, bytes_pending} < sequence_length))
    else $error("Pending byte count does not fit the open sequence length.");

endmodule
